// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/ats_pkg.sv =====
// ----------------------------------------------------------------------------
// ats_pkg
// Widths, constants and sequencer state type for the arcsin series block.
// ----------------------------------------------------------------------------
`default_nettype none

package ats_pkg;

    localparam int ARG_W     = 16;
    localparam int RES_W     = 32;
    localparam int CFG_W     = 7;
    localparam int MAG_W     = 15;
    localparam int X2_W      = 29;
    localparam int TERM_W    = 31;
    localparam int COEF_W    = 16;
    localparam int PROD_W    = 46;
    localparam int MUL_P_W   = TERM_W + X2_W;
    localparam int DIV_CNT_W = 5;

    localparam logic [MAG_W+1:0] ONE_Q14   = 17'd16384;
    localparam logic [CFG_W-1:0] CFG_RESET = 7'd16;
    localparam int               X2_SHIFT  = 28;
    localparam int               Q14_TO_Q30 = 16;

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_SQR  = 6'b000010,
        S_MUL1 = 6'b000100,
        S_MUL2 = 6'b001000,
        S_DIV  = 6'b010000,
        S_DONE = 6'b100000
    } t_state;

endpackage

`default_nettype wire

// ===== src/arcsin_taylor_series.sv =====
// ----------------------------------------------------------------------------
// arcsin_taylor_series
// arcsin(x) for Q2.14 x as a truncated Maclaurin sum in Q2.30, one shared
// multiplier and a serial divider stepped by a small sequencer.
//
//   channel  direction  handshake              payload
//   input    in         i_start / o_busy       i_arg_value
//   result   out        o_valid (strobe)       o_arcsin_value, o_domain_error
//   config   in         i_cfg_we               i_cfg_data (num_terms)
//
// An in-domain item passes the squaring step, then the two multiplier steps and
// the divide step for each of the n - 1 further terms, then the done step, n being
// num_terms clamped to 1..MAX_TERMS; each further term runs the radix-2 divider once.
// An out-of-domain item gives its result the cycle after transfer.
// Reset sets num_terms to 16 and leaves the block idle; no clearing pass.
// The result strobe lasts one cycle and cannot be held off.
// ----------------------------------------------------------------------------
`default_nettype none

module arcsin_taylor_series #(
    parameter int MAX_TERMS = 64
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    output logic                                   o_busy,
    input  wire logic signed [ats_pkg::ARG_W-1:0]  i_arg_value,
    input  wire logic                              i_cfg_we,
    input  wire logic [ats_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                   o_valid,
    output logic signed [ats_pkg::RES_W-1:0]       o_arcsin_value,
    output logic                                   o_domain_error
);
    import ats_pkg::*;

    localparam logic [8:0] MaxTermsW = 9'(MAX_TERMS);

    t_state              r_state;
    t_state              n_state;
    logic [CFG_W-1:0]    r_cfg;
    logic                r_valid;
    logic                n_valid;
    logic [CFG_W-1:0]    r_terms;
    logic [CFG_W-1:0]    n_terms;
    logic [CFG_W-1:0]    r_i;
    logic [CFG_W-1:0]    n_i;
    logic                r_neg;
    logic                n_neg;
    logic [MAG_W-1:0]    r_mag;
    logic [MAG_W-1:0]    n_mag;
    logic [X2_W-1:0]     r_x2;
    logic [X2_W-1:0]     n_x2;
    logic [TERM_W-1:0]   r_term;
    logic [TERM_W-1:0]   n_term;
    logic [RES_W-1:0]    r_sum;
    logic [RES_W-1:0]    n_sum;
    logic [COEF_W-1:0]   r_odd2;
    logic [COEF_W-1:0]   n_odd2;
    logic [COEF_W-1:0]   r_den;
    logic [COEF_W-1:0]   n_den;
    logic [RES_W-1:0]    r_res;
    logic [RES_W-1:0]    n_res;
    logic                r_err;
    logic                n_err;

    logic                w_accept;
    logic [MAG_W+1:0]    w_mag_full;
    logic [CFG_W-1:0]    w_terms;
    logic [TERM_W-1:0]   w_mul_a;
    logic [X2_W-1:0]     w_mul_b;
    logic [MUL_P_W-1:0]  w_mul_p;
    logic                w_div_start;
    logic                w_div_done;
    logic [TERM_W-1:0]   w_quo;
    logic [COEF_W-1:0]   w_step8;

    assign w_accept   = i_start && (r_state == S_IDLE);
    assign w_mag_full = i_arg_value[ARG_W-1] ? (17'h10000 - {1'b0, i_arg_value})
                                              : {1'b0, i_arg_value};

    always_comb begin
        priority if (r_cfg == '0) begin
            w_terms = CFG_W'(1);
        end else if ({2'b00, r_cfg} > MaxTermsW) begin
            w_terms = MaxTermsW[CFG_W-1:0];
        end else begin
            w_terms = r_cfg;
        end
    end

    always_comb begin
        w_mul_a = '0;
        w_mul_b = '0;
        unique case (r_state)
            S_SQR: begin
                w_mul_a = TERM_W'(r_mag);
                w_mul_b = X2_W'(r_mag);
            end
            S_MUL1: begin
                w_mul_a = r_term;
                w_mul_b = r_x2;
            end
            S_MUL2: begin
                w_mul_a = r_term;
                w_mul_b = X2_W'(r_odd2);
            end
            default: begin
                w_mul_a = '0;
                w_mul_b = '0;
            end
        endcase
    end

    assign w_mul_p     = MUL_P_W'(w_mul_a) * MUL_P_W'(w_mul_b);
    assign w_div_start = (r_state == S_MUL2);
    assign w_step8     = COEF_W'({r_i, 3'b000});

    ats_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_mul_p[PROD_W-1:0]),
        .i_divisor  (r_den),
        .o_done     (w_div_done),
        .o_quotient (w_quo)
    );

    always_comb begin
        n_state = r_state;
        n_valid = 1'b0;
        n_terms = r_terms;
        n_i     = r_i;
        n_neg   = r_neg;
        n_mag   = r_mag;
        n_x2    = r_x2;
        n_term  = r_term;
        n_sum   = r_sum;
        n_odd2  = r_odd2;
        n_den   = r_den;
        n_res   = r_res;
        n_err   = r_err;
        unique case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    if (w_mag_full > ONE_Q14) begin
                        n_res   = '0;
                        n_err   = 1'b1;
                        n_valid = 1'b1;
                    end else begin
                        n_neg   = i_arg_value[ARG_W-1];
                        n_mag   = w_mag_full[MAG_W-1:0];
                        n_terms = w_terms;
                        n_state = S_SQR;
                    end
                end
            end
            S_SQR: begin
                n_x2   = w_mul_p[X2_W-1:0];
                n_term = TERM_W'({r_mag, Q14_TO_Q30'(0)});
                n_sum  = RES_W'({r_mag, Q14_TO_Q30'(0)});
                n_i    = CFG_W'(1);
                n_odd2 = COEF_W'(1);
                n_den  = COEF_W'(6);
                n_state = (r_terms == CFG_W'(1)) ? S_DONE : S_MUL1;
            end
            S_MUL1: begin
                n_term  = w_mul_p[X2_SHIFT+TERM_W-1:X2_SHIFT];
                n_state = S_MUL2;
            end
            S_MUL2: begin
                n_state = S_DIV;
            end
            S_DIV: begin
                if (w_div_done) begin
                    n_term  = w_quo;
                    n_sum   = r_sum + RES_W'(w_quo);
                    n_odd2  = r_odd2 + w_step8;
                    n_den   = r_den + w_step8 + COEF_W'(6);
                    n_i     = r_i + 1'b1;
                    n_state = ((r_i + 1'b1) == r_terms) ? S_DONE : S_MUL1;
                end
            end
            S_DONE: begin
                n_res   = r_neg ? (RES_W'(0) - r_sum) : r_sum;
                n_err   = 1'b0;
                n_valid = 1'b1;
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_valid <= 1'b0;
            r_cfg   <= CFG_RESET;
        end else begin
            r_state <= n_state;
            r_valid <= n_valid;
            if (i_cfg_we) begin
                r_cfg <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_terms <= n_terms;
        r_i     <= n_i;
        r_neg   <= n_neg;
        r_mag   <= n_mag;
        r_x2    <= n_x2;
        r_term  <= n_term;
        r_sum   <= n_sum;
        r_odd2  <= n_odd2;
        r_den   <= n_den;
        r_res   <= n_res;
        r_err   <= n_err;
    end

    assign o_busy         = (r_state != S_IDLE);
    assign o_valid        = r_valid;
    assign o_arcsin_value = r_res;
    assign o_domain_error = r_err;

`include "assert_macros.svh"

    `ASSERT_NEXT(a_done_strobes, i_clk, i_rst_n, (r_state == S_DONE), o_valid, "result strobe missing after the final term")
    `ASSERT_SAME(a_err_zero, i_clk, i_rst_n, (o_valid && o_domain_error), (o_arcsin_value == '0), "domain error with nonzero result")
    `ASSERT_SAME(a_div_owned, i_clk, i_rst_n, w_div_done, (r_state == S_DIV), "divider finished outside the divide step")
    `ASSERT_NEXT(a_mul2_div, i_clk, i_rst_n, (r_state == S_MUL2), (r_state == S_DIV), "sequencer skipped the divide step")

endmodule

`default_nettype wire

// ===== src/ats_div.sv =====
// ----------------------------------------------------------------------------
// ats_div
// Radix-2 restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module ats_div (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire logic [ats_pkg::PROD_W-1:0]  i_dividend,
    input  wire logic [ats_pkg::COEF_W-1:0]  i_divisor,
    output logic                             o_done,
    output logic [ats_pkg::TERM_W-1:0]       o_quotient
);
    import ats_pkg::*;

    logic                 r_busy;
    logic                 n_busy;
    logic                 r_done;
    logic                 n_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [DIV_CNT_W-1:0] n_cnt;
    logic [COEF_W-1:0]    r_rem;
    logic [COEF_W-1:0]    n_rem;
    logic [TERM_W-1:0]    r_quo;
    logic [TERM_W-1:0]    n_quo;
    logic [COEF_W-1:0]    r_den;
    logic [COEF_W-1:0]    n_den;

    logic [COEF_W:0]      w_trial;
    logic [COEF_W:0]      w_diff;
    logic                 w_fit;

    assign w_trial = {r_rem, r_quo[TERM_W-1]};
    assign w_diff  = w_trial - {1'b0, r_den};
    assign w_fit   = (w_trial >= {1'b0, r_den});

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_den  = r_den;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = DIV_CNT_W'(TERM_W - 1);
            n_rem  = COEF_W'(i_dividend[PROD_W-1:TERM_W]);
            n_quo  = i_dividend[TERM_W-1:0];
            n_den  = i_divisor;
        end else if (r_busy) begin
            n_rem = w_fit ? w_diff[COEF_W-1:0] : w_trial[COEF_W-1:0];
            n_quo = {r_quo[TERM_W-2:0], w_fit};
            n_cnt = r_cnt - 1'b1;
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_den <= n_den;
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

`default_nettype wire
